// ===== sv/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg: shared types for the sorted key set
// Request and status codes, controller states, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_CMP,
        S_CHK,
        S_DECIDE,
        S_SHIFT,
        S_SHIFT_WR,
        S_RD_RANK,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, open search window
        logic rd_mid;    // read middle entry of window
        logic step;      // narrow window from compare
        logic rd_pos;    // read entry at final position
        logic chk;       // exact match check at position
        logic ptr_init;  // start shift pointer
        logic shift_rd;  // read neighbor of pointer
        logic shift_wr;  // write neighbor into pointer, advance
        logic ins_key;   // write new key at position
        logic rd_rank;   // read entry at rank
        logic finish;    // load result register, commit count
    } t_sks_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic more;        // search window not empty
        logic found;
        logic full;
        logic shift_more;
        logic out_free;
    } t_sks_sts;

endpackage

`default_nettype wire

// ===== sv/sks_ctrl.sv =====
// ----------------------------------------------------------------------------
// sks_ctrl: request sequencer
// Runs the bisection, the exact match check, the one-entry-at-a-time shift
// and the result hand-off by issuing commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire        [1:0] i_req_type,
    output logic             o_in_stall,
    input  sks_pkg::t_sks_sts i_sts,
    output sks_pkg::t_sks_cmd o_cmd
);

    sks_pkg::t_state r_state;
    sks_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sks_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            sks_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (sks_pkg::t_req'(i_req_type) == sks_pkg::REQ_READ) begin
                        n_state = sks_pkg::S_RD_RANK;
                    end else begin
                        n_state = sks_pkg::S_SRCH;
                    end
                end
            end
            sks_pkg::S_SRCH: begin
                if (i_sts.more) begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = sks_pkg::S_SRCH_CMP;
                end else begin
                    o_cmd.rd_pos = 1'b1;
                    n_state      = sks_pkg::S_CHK;
                end
            end
            sks_pkg::S_SRCH_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = sks_pkg::S_SRCH;
            end
            sks_pkg::S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = sks_pkg::S_DECIDE;
            end
            sks_pkg::S_DECIDE: begin
                if ((i_sts.req == sks_pkg::REQ_INSERT && !i_sts.found && !i_sts.full) ||
                    (i_sts.req == sks_pkg::REQ_REMOVE && i_sts.found)) begin
                    o_cmd.ptr_init = 1'b1;
                    n_state        = sks_pkg::S_SHIFT;
                end else begin
                    n_state = sks_pkg::S_DONE;
                end
            end
            sks_pkg::S_SHIFT: begin
                if (i_sts.shift_more) begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = sks_pkg::S_SHIFT_WR;
                end else begin
                    o_cmd.ins_key = (i_sts.req == sks_pkg::REQ_INSERT);
                    n_state       = sks_pkg::S_DONE;
                end
            end
            sks_pkg::S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = sks_pkg::S_SHIFT;
            end
            sks_pkg::S_RD_RANK: begin
                o_cmd.rd_rank = 1'b1;
                n_state       = sks_pkg::S_DONE;
            end
            sks_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = sks_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sks_pkg::S_IDLE;
            end
        endcase
    end

    // only one memory access command per cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.rd_mid, o_cmd.rd_pos, o_cmd.shift_rd, o_cmd.rd_rank,
                  o_cmd.shift_wr, o_cmd.ins_key}))
        else $error("sks_ctrl: more than one memory access at once");

    // a request is only taken in idle, and the result leaves only from done
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == sks_pkg::S_SRCH || r_state == sks_pkg::S_RD_RANK))
        else $error("sks_ctrl: load did not start a request");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == sks_pkg::S_IDLE) && !o_in_stall)
        else $error("sks_ctrl: finish did not return to idle");

endmodule

`default_nettype wire

// ===== sv/sks_dp.sv =====
// ----------------------------------------------------------------------------
// sks_dp: key store and search datapath
// Single-port key memory with registered read, bisection window, shift
// pointer, key count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_dp #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_wr_en,
    input  wire               i_cfg_wr_data,
    input  wire         [1:0] i_req_type,
    input  wire        [31:0] i_key,
    input  wire         [5:0] i_rank,
    input  sks_pkg::t_sks_cmd i_cmd,
    output sks_pkg::t_sks_sts o_sts,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic        [1:0] o_status,
    output logic              o_found,
    output logic       [31:0] o_key_out,
    output logic        [5:0] o_position,
    output logic        [6:0] o_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [KEY_WIDTH-1:0] SIGN_MASK = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    logic [KEY_WIDTH-1:0] r_mem [CAPACITY];
    logic [KEY_WIDTH-1:0] r_rd_data;

    logic                 r_cmp_signed;
    sks_pkg::t_req        r_req;
    logic [KEY_WIDTH-1:0] r_key;
    logic [5:0]           r_rank;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [CW-1:0]        r_mid;
    logic [CW-1:0]        r_ptr;
    logic                 r_found;

    logic                 r_out_valid;
    sks_pkg::t_status     r_status;
    logic                 r_out_found;
    logic [31:0]          r_key_out;
    logic [5:0]           r_position;
    logic [6:0]           r_out_count;

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic [CW-1:0]        mid;
    logic [CW-1:0]        nbr;
    logic                 key_gt;
    logic                 key_eq;
    logic                 full;
    logic                 is_ins;
    logic                 rank_ok;
    logic                 shift_more;

    assign is_ins  = (r_req == sks_pkg::REQ_INSERT);
    assign full    = (r_count >= CW'(CAPACITY));
    assign rank_ok = (32'(r_rank) < 32'(r_count));
    assign mid     = CW'(((CW + 1)'(r_lo) + (CW + 1)'(r_hi)) >> 1);
    assign nbr     = is_ins ? (r_ptr - CW'(1)) : (r_ptr + CW'(1));
    assign key_eq  = (r_key == r_rd_data);
    // signed order is unsigned order with the sign bits flipped
    assign key_gt  = ((r_key ^ (r_cmp_signed ? SIGN_MASK : '0)) >
                      (r_rd_data ^ (r_cmp_signed ? SIGN_MASK : '0)));
    assign shift_more = is_ins ? (r_ptr > r_hi)
                               : ((CW + 1)'(r_ptr) + (CW + 1)'(1) < (CW + 1)'(r_count));

    always_comb begin
        rd_en   = i_cmd.rd_mid | i_cmd.rd_pos | i_cmd.shift_rd | i_cmd.rd_rank;
        rd_addr = r_hi[IW-1:0];
        if (i_cmd.rd_mid) begin
            rd_addr = mid[IW-1:0];
        end else if (i_cmd.shift_rd) begin
            rd_addr = nbr[IW-1:0];
        end else if (i_cmd.rd_rank) begin
            rd_addr = IW'(r_rank);
        end
        wr_en   = i_cmd.shift_wr | i_cmd.ins_key;
        wr_addr = i_cmd.shift_wr ? r_ptr[IW-1:0] : r_hi[IW-1:0];
        wr_data = i_cmd.shift_wr ? r_rd_data : r_key;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // search window, shift pointer, request fields, match flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= sks_pkg::t_req'(i_req_type);
            r_key  <= KEY_WIDTH'(i_key);
            r_rank <= i_rank;
            r_lo   <= '0;
            r_hi   <= r_count;
        end
        if (i_cmd.rd_mid) begin
            r_mid <= mid;
        end
        if (i_cmd.step) begin
            if (key_eq) begin
                // hit closes the window on mid
                r_lo <= r_mid;
                r_hi <= r_mid;
            end else if (key_gt) begin
                r_lo <= r_mid + CW'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.chk) begin
            r_found <= (r_hi < r_count) && key_eq;
        end
        if (i_cmd.ptr_init) begin
            r_ptr <= is_ins ? r_count : r_hi;
        end else if (i_cmd.shift_wr) begin
            r_ptr <= nbr;
        end
    end

    // control state: mode register, key count, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_signed <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cmp_signed <= i_cfg_wr_data;
            end
            if (i_cmd.finish) begin
                if (is_ins && !r_found && !full) begin
                    r_count <= r_count + CW'(1);
                end else if (r_req == sks_pkg::REQ_REMOVE && r_found) begin
                    r_count <= r_count - CW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_found <= (r_req != sks_pkg::REQ_READ) && r_found;
            r_key_out   <= 32'(r_key);
            r_position  <= 6'(r_hi);
            r_out_count <= 7'(r_count);
            unique case (r_req)
                sks_pkg::REQ_INSERT: begin
                    if (r_found) begin
                        r_status <= sks_pkg::ST_MISS;
                    end else if (full) begin
                        r_status <= sks_pkg::ST_FULL;
                    end else begin
                        r_status    <= sks_pkg::ST_OK;
                        r_out_count <= 7'(r_count + CW'(1));
                    end
                end
                sks_pkg::REQ_REMOVE: begin
                    if (r_found) begin
                        r_status    <= sks_pkg::ST_OK;
                        r_out_count <= 7'(r_count - CW'(1));
                    end else begin
                        r_status <= sks_pkg::ST_MISS;
                    end
                end
                sks_pkg::REQ_LOOKUP: begin
                    r_status <= r_found ? sks_pkg::ST_OK : sks_pkg::ST_MISS;
                end
                sks_pkg::REQ_READ: begin
                    r_position <= r_rank;
                    r_status   <= rank_ok ? sks_pkg::ST_OK : sks_pkg::ST_MISS;
                    r_key_out  <= rank_ok ? 32'(r_rd_data) : '0;
                end
                default: begin
                    r_status <= sks_pkg::ST_MISS;
                end
            endcase
        end
    end

    assign o_sts.req        = r_req;
    assign o_sts.more       = (r_lo < r_hi);
    assign o_sts.found      = r_found;
    assign o_sts.full       = full;
    assign o_sts.shift_more = shift_more;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_out_found;
    assign o_key_out   = r_key_out;
    assign o_position  = r_position;
    assign o_count     = r_out_count;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !i_cmd.finish)
        else $error("sks_dp: result overwritten while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_count <= CW'(CAPACITY)))
        else $error("sks_dp: count beyond capacity");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_lo <= r_hi) && (r_hi <= r_count))
        else $error("sks_dp: search window inverted");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && is_ins && !r_found && !full) |=>
            (r_count == $past(r_count) + CW'(1)))
        else $error("sks_dp: insert did not grow count");

endmodule

`default_nettype wire

// ===== sv/sorted_key_set.sv =====
// ----------------------------------------------------------------------------
// sorted_key_set: ordered set of distinct keys with binary search
// Insert, remove, lookup and read-at-rank over a fixed store kept sorted.
//
//   channel   dir   handshake                     payload
//   in        in    i_in_valid / o_in_stall       i_req_type, i_key, i_rank
//   out       out   o_out_valid / i_out_stall     o_status, o_found, o_key_out,
//                                                 o_position, o_count
//   cfg       in    i_cfg_wr_en                   i_cfg_wr_data (compare_signed)
//
// Read at rank: a rank read, then the result. Other requests: S bisection steps
// (up to ceil(log2(n+1))), the match check, and, when an insert or remove changes
// the store, a read then a write per entry moved, as the key memory is single-port.
// One request in work at a time; a result may wait in the output register while
// the next request is taken, and holds the following one back while stalled.
// Reset clears the count and the mode; the memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_set #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_wr_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire   [1:0] i_req_type,
    input  wire  [31:0] i_key,
    input  wire   [5:0] i_rank,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic  [1:0] o_status,
    output logic        o_found,
    output logic [31:0] o_key_out,
    output logic  [5:0] o_position,
    output logic  [6:0] o_count
);

    sks_pkg::t_sks_cmd cmd;
    sks_pkg::t_sks_sts sts;

    sks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sks_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_rank        (i_rank),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_key_out     (o_key_out),
        .o_position    (o_position),
        .o_count       (o_count)
    );

endmodule

`default_nettype wire
